// ===== src/ctyr_pkg.sv =====
// Shared types, constants and tables of the coordinated-turn yaw rate block.
package ctyr_pkg;

    // Input transfer payload
    typedef struct packed {
        logic               valid_req;
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] pitch_rate_target;
        logic        [15:0] air_speed;
        logic signed [15:0] roll_target;
    } t_in;

    // Output transfer payload
    typedef struct packed {
        logic signed [15:0] yaw_rate_out;
        logic               held;
    } t_out;

    // Status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_stat;

    // CORDIC datapath width (Q30 values plus sign and headroom)
    localparam int CW = 34;
    localparam int C_STEPS = 16;
    localparam int C_CNT_W = $clog2(C_STEPS);

    localparam logic signed [CW-1:0] C_GAIN   = 34'sd652032874;
    localparam logic signed [CW-1:0] C_HALFPI = 34'sd1686629713;
    localparam logic signed [CW-1:0] C_PI     = 34'sd3373259426;

    // Serial multiplier and divider widths
    localparam int MUL_AW = 64;
    localparam int MUL_BW = 32;
    localparam int DIV_NW = 56;
    localparam int DIV_DW = 48;

    // Roll bounds in Q13
    localparam logic signed [15:0] ROLL_INV = 16'sd12868;
    localparam logic signed [17:0] ROLL_LIM = 18'sd11438;

    // g in Q16 times 16
    localparam logic signed [MUL_BW-1:0] GRAV_X16 = 32'sd10283024;

    // Register map
    localparam logic REG_MAX_YAW = 1'b0;
    localparam logic [14:0] MAX_YAW_RST = 15'd2048;

    // arctan(2^-i) in Q30
    function automatic logic signed [CW-1:0] atan_q30(input logic [C_CNT_W-1:0] i);
        logic signed [CW-1:0] v;
        case (i)
            4'd0:    v = 34'sh03243F6A8;
            4'd1:    v = 34'sh01DAC6705;
            4'd2:    v = 34'sh00FADBAFC;
            4'd3:    v = 34'sh007F56EA6;
            4'd4:    v = 34'sh003FEAB76;
            4'd5:    v = 34'sh001FFD55B;
            4'd6:    v = 34'sh000FFFAAA;
            4'd7:    v = 34'sh0007FFF55;
            4'd8:    v = 34'sh0003FFFEA;
            4'd9:    v = 34'sh0001FFFFD;
            4'd10:   v = 34'sh0000FFFFF;
            4'd11:   v = 34'sh00007FFFF;
            4'd12:   v = 34'sh00003FFFF;
            4'd13:   v = 34'sh00001FFFF;
            4'd14:   v = 34'sh00000FFFF;
            default: v = 34'sh000007FFF;
        endcase
        return v;
    endfunction

endpackage

// ===== src/coordinated_turn_yaw_rate.sv =====
// Top level of the coordinated-turn yaw rate block: sequencer, register port, output register.
// One item gives one result. An invalid item, inverted flight or zero airspeed goes from
// idle straight to the finish state. A full computation runs three 16-step CORDIC passes on
// one shared rotator, six products on one bit-serial multiplier that takes 32 multiplier bits
// at one per cycle, and a 56-bit serial division, one after another. A new item is taken
// only when the previous one has left the sequencer, while its result may still wait in the
// output register. The yaw limit register lies at byte address 0.
module coordinated_turn_yaw_rate (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ctyr_pkg::t_in     i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output ctyr_pkg::t_out    o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_COR_R = 4'd1;
    localparam logic [3:0] S_COR_P = 4'd2;
    localparam logic [3:0] S_COR_Q = 4'd3;
    localparam logic [3:0] S_MUL1  = 4'd4;
    localparam logic [3:0] S_MUL2  = 4'd5;
    localparam logic [3:0] S_MUL3  = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_MUL4  = 4'd8;
    localparam logic [3:0] S_MUL5  = 4'd9;
    localparam logic [3:0] S_MUL6  = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;

    localparam int AW = ctyr_pkg::MUL_AW;
    localparam int BW = ctyr_pkg::MUL_BW;
    localparam int CW = ctyr_pkg::CW;

    logic [3:0]           r_state;
    logic                 r_launch;
    ctyr_pkg::t_in        r_in;
    logic signed [15:0]   r_r;
    logic signed [CW-1:0] r_sr, r_cr, r_cp, r_sbr, r_cbr;
    logic signed [AW-1:0] r_t1, r_num, r_eul, r_c2, r_p3;
    logic [ctyr_pkg::DIV_DW-1:0] r_den;
    logic signed [15:0]   r_res, r_last;
    logic                 r_held;
    logic [14:0]          r_max;
    logic                 r_out_valid;
    ctyr_pkg::t_out       r_out;

    logic                 in_take, out_free, inverted;
    logic signed [17:0]   roll_x, lim_x, rc;
    logic signed [15:0]   cor_ang;
    logic signed [CW-1:0] cor_sin, cor_cos;
    logic signed [AW-1:0] mul_a, mul_p, div_q, acc;
    logic signed [BW-1:0] mul_b;
    logic                 cor_start, mul_start, div_start;
    logic                 is_cor, is_mul;
    ctyr_pkg::t_stat      cor_stat, mul_stat, div_stat;

    // register port
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= ctyr_pkg::MAX_YAW_RST;
        end else if (psel && penable && pwrite && paddr[2] == ctyr_pkg::REG_MAX_YAW) begin
            r_max <= pwdata[14:0];
        end
    end
    assign prdata = (paddr[2] == ctyr_pkg::REG_MAX_YAW) ? {17'b0, r_max} : 32'b0;

    // input screening and roll clamp
    assign in_take  = (r_state == S_IDLE) && i_in_valid;
    assign inverted = (i_in_data.roll_angle >= ctyr_pkg::ROLL_INV)
                   || (i_in_data.roll_angle <= -ctyr_pkg::ROLL_INV);
    always_comb begin
        roll_x = {{2{i_in_data.roll_angle[15]}}, i_in_data.roll_angle};
        lim_x  = {{2{i_in_data.roll_target[15]}}, i_in_data.roll_target};
        if (lim_x < 0) begin
            lim_x = -lim_x;
        end
        rc = roll_x;
        if (rc > ctyr_pkg::ROLL_LIM) rc = ctyr_pkg::ROLL_LIM;
        if (rc < -ctyr_pkg::ROLL_LIM) rc = -ctyr_pkg::ROLL_LIM;
        if (rc > lim_x) rc = lim_x;
        if (rc < -lim_x) rc = -lim_x;
    end

    // unit launch and operand selection
    assign is_cor = (r_state == S_COR_R) || (r_state == S_COR_P) || (r_state == S_COR_Q);
    assign is_mul = (r_state == S_MUL1) || (r_state == S_MUL2) || (r_state == S_MUL3)
                 || (r_state == S_MUL4) || (r_state == S_MUL5) || (r_state == S_MUL6);
    assign cor_start = is_cor && !r_launch;
    assign mul_start = is_mul && !r_launch;
    assign div_start = (r_state == S_DIV) && !r_launch;

    always_comb begin
        case (r_state)
            S_COR_P: cor_ang = r_in.pitch_angle;
            S_COR_Q: cor_ang = r_in.roll_angle;
            default: cor_ang = r_r;
        endcase
    end

    always_comb begin
        case (r_state)
            S_MUL2: begin
                mul_a = r_t1;
                mul_b = ctyr_pkg::GRAV_X16;
            end
            S_MUL3: begin
                mul_a = AW'(r_cr);
                mul_b = BW'({16'b0, r_in.air_speed});
            end
            S_MUL4: begin
                mul_a = AW'(r_cbr);
                mul_b = r_cp[BW-1:0];
            end
            S_MUL5: begin
                mul_a = r_c2;
                mul_b = r_eul[BW-1:0];
            end
            S_MUL6: begin
                mul_a = AW'(r_sbr);
                mul_b = BW'(r_in.pitch_rate_target);
            end
            default: begin
                mul_a = AW'(r_sr);
                mul_b = r_cp[BW-1:0];
            end
        endcase
    end

    ctyr_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_angle (cor_ang),
        .o_sin   (cor_sin),
        .o_cos   (cor_cos),
        .o_stat  (cor_stat)
    );

    ctyr_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_p     (mul_p),
        .o_stat  (mul_stat)
    );

    ctyr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_quo   (div_q),
        .o_stat  (div_stat)
    );

    // body rate sum in Q42 down to Q12
    assign acc = (r_p3 - mul_p) >>> 30;

    assign out_free = !r_out_valid || !i_out_stall;

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_launch <= 1'b0;
        end else begin
            if (cor_start || mul_start || div_start) begin
                r_launch <= 1'b1;
            end
            if (cor_stat.done || mul_stat.done || div_stat.done) begin
                r_launch <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        if (!i_in_data.valid_req || inverted || i_in_data.air_speed == 16'd0) begin
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_COR_R;
                        end
                    end
                end
                S_COR_R: if (cor_stat.done) r_state <= S_COR_P;
                S_COR_P: if (cor_stat.done) r_state <= S_COR_Q;
                S_COR_Q: if (cor_stat.done) r_state <= S_MUL1;
                S_MUL1:  if (mul_stat.done) r_state <= S_MUL2;
                S_MUL2:  if (mul_stat.done) r_state <= S_MUL3;
                S_MUL3:  if (mul_stat.done) r_state <= S_DIV;
                S_DIV:   if (div_stat.done) r_state <= S_MUL4;
                S_MUL4:  if (mul_stat.done) r_state <= S_MUL5;
                S_MUL5:  if (mul_stat.done) r_state <= S_MUL6;
                S_MUL6:  if (mul_stat.done) r_state <= S_FIN;
                S_FIN:   if (out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in   <= i_in_data;
            r_r    <= rc[15:0];
            r_held <= !i_in_data.valid_req || inverted;
            r_res  <= (!i_in_data.valid_req || inverted) ? r_last : 16'sd0;
        end
        if (cor_stat.done) begin
            case (r_state)
                S_COR_R: begin
                    r_sr <= cor_sin;
                    r_cr <= cor_cos;
                end
                S_COR_P: r_cp <= cor_cos;
                default: begin
                    r_sbr <= cor_sin;
                    r_cbr <= cor_cos;
                end
            endcase
        end
        if (mul_stat.done) begin
            case (r_state)
                S_MUL1: r_t1  <= mul_p >>> 30;
                S_MUL2: r_num <= mul_p;
                S_MUL3: r_den <= mul_p[ctyr_pkg::DIV_DW-1:0];
                S_MUL4: r_c2  <= mul_p >>> 30;
                S_MUL5: r_p3  <= mul_p;
                default: begin
                    if (acc > $signed({49'b0, r_max})) begin
                        r_res <= $signed({1'b0, r_max});
                    end else if (acc < -$signed({49'b0, r_max})) begin
                        r_res <= -$signed({1'b0, r_max});
                    end else begin
                        r_res <= acc[15:0];
                    end
                end
            endcase
        end
        if (div_stat.done) begin
            r_eul <= div_q;
        end
    end

    // result store and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_last      <= '0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
                r_last      <= r_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && out_free) begin
            r_out <= '{yaw_rate_out: r_res, held: r_held};
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // a pending result always matches the stored rate
    a_out_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.yaw_rate_out == r_last)
        else $error("pending result differs from stored rate");

    // a fresh result respects the limit
    a_out_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.held) |->
        (r_out.yaw_rate_out <= $signed({1'b0, r_max})
         && r_out.yaw_rate_out >= -$signed({1'b0, r_max})))
        else $error("fresh result beyond yaw limit");

    // a finished result waits while the output register is blocked
    a_fin_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_out_valid && i_out_stall) |=> r_state == S_FIN)
        else $error("result dropped while output blocked");

    // only one arithmetic unit runs at a time
    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cor_stat.busy, mul_stat.busy, div_stat.busy}))
        else $error("arithmetic units overlap");
endmodule

// ===== src/ctyr_cordic.sv =====
// Iterative rotation-mode CORDIC: sine and cosine of a Q13 angle, one step a cycle.
module ctyr_cordic (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [15:0]            i_angle,
    output logic signed [ctyr_pkg::CW-1:0] o_sin,
    output logic signed [ctyr_pkg::CW-1:0] o_cos,
    output ctyr_pkg::t_stat               o_stat
);
    logic signed [ctyr_pkg::CW-1:0] r_x, r_y, r_z;
    logic                           r_neg;
    logic [ctyr_pkg::C_CNT_W-1:0]   r_cnt;
    logic                           r_busy, r_done;
    logic signed [ctyr_pkg::CW-1:0] z0, zf, sh_x, sh_y, at;

    // widen to Q30 and fold into [-pi/2, pi/2]
    always_comb begin
        z0 = {i_angle[15], i_angle, 17'b0};
        zf = z0;
        if (z0 > ctyr_pkg::C_HALFPI) begin
            zf = ctyr_pkg::C_PI - z0;
        end else if (z0 < -ctyr_pkg::C_HALFPI) begin
            zf = -ctyr_pkg::C_PI - z0;
        end
    end

    assign sh_x = r_x >>> r_cnt;
    assign sh_y = r_y >>> r_cnt;
    assign at   = ctyr_pkg::atan_q30(r_cnt);

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= ctyr_pkg::C_GAIN;
            r_y   <= '0;
            r_z   <= zf;
            r_neg <= (z0 > ctyr_pkg::C_HALFPI) || (z0 < -ctyr_pkg::C_HALFPI);
        end else if (r_busy) begin
            if (!r_z[ctyr_pkg::CW-1]) begin
                r_x <= r_x - sh_y;
                r_y <= r_y + sh_x;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + sh_y;
                r_y <= r_y - sh_x;
                r_z <= r_z + at;
            end
        end
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ctyr_pkg::C_CNT_W'(ctyr_pkg::C_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_sin  = r_y;
    assign o_cos  = r_neg ? -r_x : r_x;
    assign o_stat = '{busy: r_busy, done: r_done};
endmodule

// ===== src/ctyr_mul.sv =====
// Bit-serial signed multiplier: one multiplier bit per cycle, sign-magnitude.
module ctyr_mul (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [ctyr_pkg::MUL_AW-1:0] i_a,
    input  logic signed [ctyr_pkg::MUL_BW-1:0] i_b,
    output logic signed [ctyr_pkg::MUL_AW-1:0] o_p,
    output ctyr_pkg::t_stat                   o_stat
);
    localparam int CNT_W = $clog2(ctyr_pkg::MUL_BW);

    logic [ctyr_pkg::MUL_AW-1:0] r_a, r_acc;
    logic [ctyr_pkg::MUL_BW-1:0] r_b;
    logic                        r_neg, r_busy, r_done;
    logic [CNT_W-1:0]            r_cnt;

    // shift-add datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a[ctyr_pkg::MUL_AW-1] ? -i_a : i_a;
            r_b   <= i_b[ctyr_pkg::MUL_BW-1] ? -i_b : i_b;
            r_neg <= i_a[ctyr_pkg::MUL_AW-1] ^ i_b[ctyr_pkg::MUL_BW-1];
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= {r_a[ctyr_pkg::MUL_AW-2:0], 1'b0};
            r_b <= {1'b0, r_b[ctyr_pkg::MUL_BW-1:1]};
        end
    end

    // bit counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ctyr_pkg::MUL_BW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_p    = r_neg ? -$signed(r_acc) : $signed(r_acc);
    assign o_stat = '{busy: r_busy, done: r_done};
endmodule

// ===== src/ctyr_div.sv =====
// Restoring serial divider: signed numerator, positive divisor, quotient toward zero.
module ctyr_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [ctyr_pkg::MUL_AW-1:0] i_num,
    input  logic [ctyr_pkg::DIV_DW-1:0]       i_den,
    output logic signed [ctyr_pkg::MUL_AW-1:0] o_quo,
    output ctyr_pkg::t_stat                   o_stat
);
    localparam int CNT_W = $clog2(ctyr_pkg::DIV_NW);

    logic [ctyr_pkg::DIV_NW-1:0] r_n;
    logic [ctyr_pkg::DIV_DW-1:0] r_d, r_rem, trial;
    logic                        r_neg, r_busy, r_done, fits;
    logic [CNT_W-1:0]            r_cnt;
    logic [ctyr_pkg::MUL_AW-1:0] num_mag;

    assign num_mag = i_num[ctyr_pkg::MUL_AW-1] ? -i_num : i_num;
    assign trial   = {r_rem[ctyr_pkg::DIV_DW-2:0], r_n[ctyr_pkg::DIV_NW-1]};
    assign fits    = trial >= r_d;

    // one quotient bit per cycle; r_n turns into the quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= num_mag[ctyr_pkg::DIV_NW-1:0];
            r_d   <= i_den;
            r_rem <= '0;
            r_neg <= i_num[ctyr_pkg::MUL_AW-1];
        end else if (r_busy) begin
            r_rem <= fits ? trial - r_d : trial;
            r_n   <= {r_n[ctyr_pkg::DIV_NW-2:0], fits};
        end
    end

    // bit counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ctyr_pkg::DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        o_quo = $signed({{(ctyr_pkg::MUL_AW - ctyr_pkg::DIV_NW){1'b0}}, r_n});
        if (r_neg) begin
            o_quo = -o_quo;
        end
    end

    assign o_stat = '{busy: r_busy, done: r_done};
endmodule

// ===== dv/tb_coordinated_turn_yaw_rate.sv =====
// Self-checking testbench of the coordinated-turn yaw rate block with a fixed-point predictor.
module tb_coordinated_turn_yaw_rate;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int N_RANDOM = 1900;
    localparam int SETTLE_CYCLES = 400;
    localparam int HOLD_CYCLES = 3000;
    localparam logic [2:0] ADDR_MAX_YAW = 3'd0;

    localparam longint ROLL_INV_Q = 12868;
    localparam longint ROLL_LIM_Q = 11438;
    localparam longint PI_Q30 = 64'sd3373259426;
    localparam longint HALFPI_Q30 = 64'sd1686629713;
    localparam longint GAIN_Q30 = 64'sd652032874;
    localparam longint GRAV_Q16 = 64'sd642689;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    ctyr_pkg::t_in i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    ctyr_pkg::t_out o_out_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    coordinated_turn_yaw_rate dut (.*);

    always #2 i_clk = ~i_clk;

    // predictor state
    logic [14:0] yaw_limit;
    logic signed [15:0] stored_yaw;
    ctyr_pkg::t_out yaw_expect_q[$];

    int mismatches = 0;
    int idle_cycles = 0;
    bit hold_off = 1'b0;

    longint atan_tab[16] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
        64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
        64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF};

    // CORDIC sine and cosine in Q30 of a Q13 angle
    task automatic rotate_q13(input longint ang, output longint s, output longint c);
        longint z, x, y, nx;
        bit flip;
        z = ang * 131072;
        flip = 1'b0;
        x = GAIN_Q30;
        y = 0;
        if (z > HALFPI_Q30) begin
            z = PI_Q30 - z;
            flip = 1'b1;
        end else if (z < -HALFPI_Q30) begin
            z = -PI_Q30 - z;
            flip = 1'b1;
        end
        for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= atan_tab[i];
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += atan_tab[i];
            end
            x = nx;
        end
        s = y;
        c = flip ? -x : x;
    endtask

    // expected body yaw rate for one item; updates the stored rate
    task automatic predict_yaw(input ctyr_pkg::t_in it);
        longint roll, rc, lim, sr, cr, sp, cp, s_r, c_r, t1, euler, acc, lim64;
        ctyr_pkg::t_out res;
        roll = longint'(it.roll_angle);
        res.held = 1'b0;
        if (!it.valid_req || roll >= ROLL_INV_Q || roll <= -ROLL_INV_Q) begin
            res.yaw_rate_out = stored_yaw;
            res.held = 1'b1;
        end else if (it.air_speed == 0) begin
            res.yaw_rate_out = '0;
        end else begin
            rc = roll;
            if (rc > ROLL_LIM_Q) rc = ROLL_LIM_Q;
            if (rc < -ROLL_LIM_Q) rc = -ROLL_LIM_Q;
            lim = longint'(it.roll_target);
            if (lim < 0) lim = -lim;
            if (rc > lim) rc = lim;
            if (rc < -lim) rc = -lim;
            rotate_q13(rc, sr, cr);
            rotate_q13(longint'(it.pitch_angle), sp, cp);
            rotate_q13(roll, s_r, c_r);
            t1 = (sr * cp) >>> 30;
            euler = (t1 * GRAV_Q16 * 16) / (cr * longint'({48'd0, it.air_speed}));
            acc = -s_r * longint'(it.pitch_rate_target) + ((c_r * cp) >>> 30) * euler;
            acc = acc >>> 30;
            lim64 = longint'({49'd0, yaw_limit});
            if (acc > lim64) acc = lim64;
            if (acc < -lim64) acc = -lim64;
            res.yaw_rate_out = acc[15:0];
        end
        if (!res.held) stored_yaw = res.yaw_rate_out;
        yaw_expect_q.push_back(res);
    endtask

    // register write: setup then access phase
    task automatic write_limit(input logic [14:0] v);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_MAX_YAW;
        pwdata <= {17'd0, v};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        yaw_limit = v;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // one input transfer, with a random gap before it; valid stays up across a zero gap
    task automatic send_item(input ctyr_pkg::t_in it);
        int gap;
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_data <= it;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_yaw(it);
        @(negedge i_clk);
    endtask

    // stop offering and wait until every expected result has come
    task automatic drain_wait();
        i_in_valid <= 1'b0;
        while (yaw_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic ctyr_pkg::t_in rand_item();
        ctyr_pkg::t_in it;
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        it = raw[$bits(ctyr_pkg::t_in)-1:0];
        it.valid_req = ($urandom_range(0, 9) != 0);
        case ($urandom_range(0, 5))
            0: it.roll_angle = 16'($urandom_range(0, 32767) - 16384);
            1: it.air_speed = 16'($urandom_range(0, 3));
            2: it.roll_target = 16'($urandom_range(0, 200) - 100);
            default: begin
                it.roll_angle = 16'($urandom_range(0, 25736) - 12868);
                it.air_speed = 16'($urandom_range(256, 12800));
            end
        endcase
        return it;
    endfunction

    // receiver side: random wait per result, plus one long hold-off
    initial begin
        int wait_n;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_off) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_off = 1'b0;
            end
            wait_n = $urandom_range(0, 6);
            if (wait_n != 0) begin
                i_out_stall <= 1'b1;
                repeat (wait_n) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    // output check
    always @(posedge i_clk) begin
        ctyr_pkg::t_out exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (yaw_expect_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", o_out_data);
            end else begin
                exp_r = yaw_expect_q.pop_front();
                if (o_out_data.yaw_rate_out !== exp_r.yaw_rate_out
                    || o_out_data.held !== exp_r.held) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("yaw mismatch: exp %0d held %b, got %0d held %b",
                                 exp_r.yaw_rate_out, exp_r.held,
                                 o_out_data.yaw_rate_out, o_out_data.held);
                end
            end
        end
    end

    // watchdog on transfers
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[coordinated_turn_yaw_rate] ERROR");
            $finish;
        end
    end

    // directed rows: fields plus expected output where obvious
    typedef struct {
        ctyr_pkg::t_in it;
        bit known;
        logic signed [15:0] yaw;
        logic held;
    } t_row;

    t_row dir_rows[$];

    function automatic ctyr_pkg::t_in mk(logic v, int r, int p, int q, int a, int t);
        ctyr_pkg::t_in it;
        it.valid_req = v;
        it.roll_angle = 16'(r);
        it.pitch_angle = 16'(p);
        it.pitch_rate_target = 16'(q);
        it.air_speed = 16'(a);
        it.roll_target = 16'(t);
        return it;
    endfunction

    function automatic t_row row(ctyr_pkg::t_in it, bit k, int y, logic h);
        t_row r;
        r.it = it;
        r.known = k;
        r.yaw = 16'(y);
        r.held = h;
        return r;
    endfunction

    initial begin
        yaw_limit = ctyr_pkg::MAX_YAW_RST;
        stored_yaw = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // held after reset, zero airspeed, inverted flight, extremes
        dir_rows.push_back(row(mk(0, 1000, 0, 0, 256, 4000), 1, 0, 1));
        dir_rows.push_back(row(mk(1, 1000, 0, 0, 0, 4000), 1, 0, 0));
        dir_rows.push_back(row(mk(1, 12868, 0, 0, 256, 4000), 1, 0, 1));
        dir_rows.push_back(row(mk(1, -12868, 0, 0, 256, 4000), 1, 0, 1));
        dir_rows.push_back(row(mk(1, 32767, 32767, 32767, 65535, 32767), 1, 0, 1));
        dir_rows.push_back(row(mk(1, -32768, -32768, -32768, 65535, -32768), 1, 0, 1));
        dir_rows.push_back(row(mk(1, 0, 0, 32767, 256, 0), 1, 0, 0));
        dir_rows.push_back(row(mk(1, 12867, 0, 0, 1, 32767), 0, 0, 0));
        dir_rows.push_back(row(mk(1, -12867, 0, 0, 1, -32768), 0, 0, 0));
        dir_rows.push_back(row(mk(0, 0, 0, 0, 0, 0), 0, 0, 1));
        dir_rows.push_back(row(mk(1, 4000, 32767, -32768, 65535, 2000), 0, 0, 0));
        dir_rows.push_back(row(mk(1, -4000, -32768, 32767, 2560, 0), 0, 0, 0));
        dir_rows.push_back(row(mk(1, 11438, 12868, 1000, 5120, 11438), 0, 0, 0));
        dir_rows.push_back(row(mk(1, 3000, 25000, -500, 3000, -20000), 0, 0, 0));
        dir_rows.push_back(row(mk(1, 2000, 0, 0, 0, 2000), 1, 0, 0));

        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].it);
            if (dir_rows[i].known) begin
                yaw_expect_q[$].yaw_rate_out = dir_rows[i].yaw;
                yaw_expect_q[$].held = dir_rows[i].held;
            end
        end
        drain_wait();

        // random phases over several limits, extremes included
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_limit(15'd0);
                1: write_limit(15'h7FFF);
                2: write_limit(15'($urandom_range(1, 32766)));
                default: write_limit(ctyr_pkg::MAX_YAW_RST);
            endcase
            if (ph == 1) hold_off = 1'b1;
            for (int n = 0; n < N_RANDOM / 4; n++) begin
                send_item(rand_item());
                if (ph == 2 && n == 100) drain_wait();
            end
            drain_wait();
        end

        if (mismatches == 0 && yaw_expect_q.size() == 0) begin
            $display("[coordinated_turn_yaw_rate] OK");
        end else begin
            $display("[coordinated_turn_yaw_rate] ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/ctyr_pkg.sv
src/ctyr_cordic.sv
src/ctyr_mul.sv
src/ctyr_div.sv
src/coordinated_turn_yaw_rate.sv
dv/tb_coordinated_turn_yaw_rate.sv
